// ===== rtl/lcs_pkg.sv =====
// Shared constants, codes and types for the line command servo limit controller.
package lcs_pkg;

  localparam int LCS_LINE_DEPTH  = 64;
  localparam int LCS_FIELD_COUNT = 4;
  localparam int LCS_IDX_W       = $clog2(LCS_FIELD_COUNT + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int PULSE_W = 12;
  localparam int STEP_W  = 10;
  localparam int ANGLE_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_PULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Z_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_OPEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_CLOSE   = 3'd5;

  localparam logic [PULSE_W-1:0]       RST_STOP_PULSE = 12'd1500;
  localparam logic signed [STEP_W-1:0] RST_X_STEP     = 10'sd100;
  localparam logic signed [STEP_W-1:0] RST_Y_STEP     = -10'sd100;
  localparam logic signed [STEP_W-1:0] RST_Z_STEP     = 10'sd100;
  localparam logic [ANGLE_W-1:0]       RST_ARM_OPEN   = 8'd45;
  localparam logic [ANGLE_W-1:0]       RST_ARM_CLOSE  = 8'd0;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [1:0] x_dir;
    logic [1:0] y_dir;
    logic [1:0] z_dir;
    logic [1:0] arm_code;
  } lcs_parse_t;

endpackage

// ===== rtl/lcs_in_if.sv =====
// Input channel: characters and servo update ticks with limit switch states.
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_byte;
  logic       x_start_hit;
  logic       x_end_hit;
  logic       y_start_hit;
  logic       y_end_hit;
  logic       z_top_hit;

  modport source (
    output valid, command, char_byte, x_start_hit, x_end_hit, y_start_hit, y_end_hit,
           z_top_hit,
    input  ready
  );
  modport sink (
    input  valid, command, char_byte, x_start_hit, x_end_hit, y_start_hit, y_end_hit,
           z_top_hit,
    output ready
  );
endinterface

// ===== rtl/lcs_out_if.sv =====
// Result channel: servo pulse widths and arm angle.
interface lcs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pulse_x;
  logic [11:0] pulse_y;
  logic [11:0] pulse_z;
  logic [7:0]  arm_angle;

  modport source (
    output valid, pulse_x, pulse_y, pulse_z, arm_angle,
    input  ready
  );
  modport sink (
    input  valid, pulse_x, pulse_y, pulse_z, arm_angle,
    output ready
  );
endinterface

// ===== rtl/lcs_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface lcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/lcs_ram.sv =====
// Generic single write port RAM with registered read.
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lcs_line_parser.sv =====
// Line buffer and sequential field reader that turns a command line into direction codes.
module lcs_line_parser #(
  parameter int LINE_DEPTH = lcs_pkg::LCS_LINE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                char_en,
  input  logic [7:0]          char_byte,
  output lcs_pkg::lcs_parse_t status
);

  import lcs_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] FULL_LEN = LW'(LINE_DEPTH);

  typedef enum logic [1:0] {
    P_IDLE = 2'b01,
    P_WALK = 2'b10
  } pstate_t;

  typedef enum logic [2:0] {
    F_BLANK = 3'b001,
    F_DIGIT = 3'b010,
    F_DONE  = 3'b100
  } fphase_t;

  pstate_t              pst_r, pst_nxt;
  fphase_t              fph_r, fph_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        ptr_r, ptr_nxt;
  logic                 dval_r, dval_nxt;
  logic                 done_r, done_nxt;
  logic [LCS_IDX_W-1:0] idx_r, idx_nxt;
  logic                 neg_r, neg_nxt;
  logic [1:0]           mag_r, mag_nxt;
  logic [1:0]           codes_r [LCS_FIELD_COUNT];
  logic [1:0]           codes_nxt [LCS_FIELD_COUNT];

  logic                 ram_we;
  logic [7:0]           rd_data;
  logic                 rd_issue;
  logic [1:0]           fin_code;
  logic                 is_digit;
  logic                 is_blank;
  logic [3:0]           digit;
  logic [1:0]           mag_acc;
  logic                 field_open;

  assign ram_we   = char_en && (pst_r == P_IDLE) && (char_byte != CH_CR) &&
                    (char_byte != CH_LF) && (char_byte != CH_BS) && (len_r < FULL_LEN);
  assign rd_issue = (pst_r == P_WALK) && (ptr_r < len_r);

  lcs_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (char_byte),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign fin_code   = (mag_r == 2'd1) ? (neg_r ? DIR_REV : DIR_FWD) : DIR_STOP;
  assign is_digit   = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
  assign is_blank   = (rd_data == CH_SPACE) || (rd_data == CH_TAB) || (rd_data == CH_LF) ||
                      (rd_data == CH_VT) || (rd_data == CH_FF) || (rd_data == CH_CR);
  assign digit      = rd_data[3:0];
  assign mag_acc    = ((mag_r == 2'd0) && (digit <= 4'd2)) ? digit[1:0] : 2'd2;
  assign field_open = (idx_r < LCS_IDX_W'(LCS_FIELD_COUNT));

  always_comb begin
    pst_nxt  = pst_r;
    fph_nxt  = fph_r;
    len_nxt  = len_r;
    ptr_nxt  = ptr_r;
    dval_nxt = 1'b0;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    for (int k = 0; k < LCS_FIELD_COUNT; k++) begin
      codes_nxt[k] = codes_r[k];
    end

    case (pst_r)
      P_IDLE: begin
        if (char_en) begin
          if (char_byte == CH_LF) begin
            pst_nxt = P_WALK;
            ptr_nxt = '0;
            idx_nxt = '0;
            fph_nxt = F_BLANK;
            neg_nxt = 1'b0;
            mag_nxt = 2'd0;
            for (int k = 0; k < LCS_FIELD_COUNT; k++) begin
              codes_nxt[k] = DIR_STOP;
            end
          end else if (char_byte == CH_BS) begin
            if (len_r != '0) begin
              len_nxt = len_r - 1'b1;
            end
          end else if (ram_we) begin
            len_nxt = len_r + 1'b1;
          end
        end
      end
      P_WALK: begin
        if (rd_issue) begin
          ptr_nxt  = ptr_r + 1'b1;
          dval_nxt = 1'b1;
        end
        if (dval_r && field_open) begin
          if (rd_data == CH_COMMA) begin
            codes_nxt[idx_r[1:0]] = fin_code;
            idx_nxt = idx_r + 1'b1;
            fph_nxt = F_BLANK;
            neg_nxt = 1'b0;
            mag_nxt = 2'd0;
          end else begin
            case (fph_r)
              F_BLANK: begin
                if (rd_data == CH_PLUS || rd_data == CH_MINUS) begin
                  neg_nxt = (rd_data == CH_MINUS);
                  fph_nxt = F_DIGIT;
                end else if (is_digit) begin
                  mag_nxt = mag_acc;
                  fph_nxt = F_DIGIT;
                end else if (!is_blank) begin
                  fph_nxt = F_DONE;
                end
              end
              F_DIGIT: begin
                if (is_digit) begin
                  mag_nxt = mag_acc;
                end else begin
                  fph_nxt = F_DONE;
                end
              end
              default: begin
                fph_nxt = F_DONE;
              end
            endcase
          end
        end
        if (!rd_issue && !dval_r) begin
          if (field_open) begin
            codes_nxt[idx_r[1:0]] = fin_code;
          end
          pst_nxt  = P_IDLE;
          len_nxt  = '0;
          done_nxt = 1'b1;
        end
      end
      default: begin
        pst_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pst_r  <= P_IDLE;
      len_r  <= '0;
      ptr_r  <= '0;
      dval_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      pst_r  <= pst_nxt;
      len_r  <= len_nxt;
      ptr_r  <= ptr_nxt;
      dval_r <= dval_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
    fph_r <= fph_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    for (int k = 0; k < LCS_FIELD_COUNT; k++) begin
      codes_r[k] <= codes_nxt[k];
    end
  end

  assign status.busy     = (pst_r == P_WALK) || done_r;
  assign status.done     = done_r;
  assign status.x_dir    = codes_r[0];
  assign status.y_dir    = codes_r[1];
  assign status.z_dir    = codes_r[2];
  assign status.arm_code = codes_r[3];

endmodule

// ===== rtl/lcs_pulse_unit.sv =====
// Shared adder with saturation that forms one servo pulse width from stop and step.
module lcs_pulse_unit (
  input  logic [11:0]        stop_pulse,
  input  logic signed [9:0]  step,
  input  logic [1:0]         op,
  output logic [11:0]        pulse
);

  import lcs_pkg::*;

  logic signed [13:0] stop_ext;
  logic signed [13:0] step_ext;
  logic signed [13:0] sum;

  assign stop_ext = $signed({2'b00, stop_pulse});
  assign step_ext = 14'(step);

  always_comb begin
    case (op)
      OP_ADD:  sum = stop_ext + step_ext;
      OP_SUB:  sum = stop_ext - step_ext;
      default: sum = stop_ext;
    endcase
    if (sum < 14'sd0) begin
      pulse = '0;
    end else if (sum > 14'sd4095) begin
      pulse = 12'd4095;
    end else begin
      pulse = sum[11:0];
    end
  end

endmodule

// ===== rtl/line_command_servo_limit_controller_core.sv =====
// Top level of the line command servo limit controller: sequencer, registers and channels.
// A character word is taken only while the core and field reader are idle; a line end walks
// the stored line at one character a cycle through the field reader, and the input is held
// off until the walk is done and the parsed codes have been handed over.
// A tick word runs the shared pulse adder once per axis in S_TICK, then waits in S_HOLD until
// the previous result has been taken before loading the output register; the input is ready
// again from the edge that loads it, so no new tick is taken before the result is loaded.
// Synchronous active-low reset restores the register defaults, empties the line, stops all
// axes and opens the arm; no clearing pass is needed.
module line_command_servo_limit_controller_core #(
  parameter int LINE_DEPTH = lcs_pkg::LCS_LINE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  lcs_in_if.sink    in_ch,
  lcs_out_if.source out_ch,
  lcs_cfg_if.sink   cfg_ch
);

  import lcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  state_t                     state_r, state_nxt;
  logic [1:0]                 axis_r, axis_nxt;
  logic [PULSE_W-1:0]         stop_pulse_r;
  logic signed [STEP_W-1:0]   x_step_r, y_step_r, z_step_r;
  logic [ANGLE_W-1:0]         arm_open_r, arm_close_r;
  logic [1:0]                 x_dir_r, y_dir_r, z_dir_r;
  logic                       arm_is_open_r;
  logic [4:0]                 hit_r;
  logic [PULSE_W-1:0]         px_r, py_r, pz_r;
  logic                       out_valid_r;
  logic [PULSE_W-1:0]         out_px_r, out_py_r, out_pz_r;
  logic [ANGLE_W-1:0]         out_arm_r;

  lcs_parse_t                 parse;
  logic                       in_acc;
  logic                       char_en;
  logic                       tick_acc;
  logic                       cfg_acc;
  logic                       out_load;
  logic signed [STEP_W-1:0]   sel_step;
  logic [1:0]                 sel_op;
  logic [PULSE_W-1:0]         pulse;

  assign in_ch.ready  = (state_r == S_IDLE) && !parse.busy;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign char_en      = in_acc && !in_ch.command;
  assign tick_acc     = in_acc && in_ch.command;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  lcs_line_parser #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_en   (char_en),
    .char_byte (in_ch.char_byte),
    .status    (parse)
  );

  function automatic logic [1:0] dir_op(input logic [1:0] dir);
    logic [1:0] op;
    case (dir)
      DIR_FWD: op = OP_ADD;
      DIR_REV: op = OP_SUB;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  always_comb begin
    case (axis_r)
      AX_X: begin
        sel_step = x_step_r;
        sel_op   = hit_r[0] ? OP_ADD : (hit_r[1] ? OP_SUB : dir_op(x_dir_r));
      end
      AX_Y: begin
        sel_step = y_step_r;
        sel_op   = hit_r[2] ? OP_ADD : (hit_r[3] ? OP_SUB : dir_op(y_dir_r));
      end
      AX_Z: begin
        sel_step = z_step_r;
        if (hit_r[4]) begin
          sel_op = OP_ADD;
        end else begin
          case (z_dir_r)
            DIR_FWD: sel_op = OP_SUB;
            DIR_REV: sel_op = OP_ADD;
            default: sel_op = OP_NONE;
          endcase
        end
      end
      default: begin
        sel_step = x_step_r;
        sel_op   = OP_NONE;
      end
    endcase
  end

  lcs_pulse_unit u_pulse (
    .stop_pulse (stop_pulse_r),
    .step       (sel_step),
    .op         (sel_op),
    .pulse      (pulse)
  );

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (tick_acc) begin
          state_nxt = S_TICK;
          axis_nxt  = AX_X;
        end
      end
      S_TICK: begin
        if (axis_r == AX_Z) begin
          state_nxt = S_HOLD;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      axis_r        <= AX_X;
      stop_pulse_r  <= RST_STOP_PULSE;
      x_step_r      <= RST_X_STEP;
      y_step_r      <= RST_Y_STEP;
      z_step_r      <= RST_Z_STEP;
      arm_open_r    <= RST_ARM_OPEN;
      arm_close_r   <= RST_ARM_CLOSE;
      x_dir_r       <= DIR_STOP;
      y_dir_r       <= DIR_STOP;
      z_dir_r       <= DIR_STOP;
      arm_is_open_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_STOP_PULSE: stop_pulse_r <= cfg_ch.data[PULSE_W-1:0];
          REG_X_STEP:     x_step_r     <= $signed(cfg_ch.data[STEP_W-1:0]);
          REG_Y_STEP:     y_step_r     <= $signed(cfg_ch.data[STEP_W-1:0]);
          REG_Z_STEP:     z_step_r     <= $signed(cfg_ch.data[STEP_W-1:0]);
          REG_ARM_OPEN:   arm_open_r   <= cfg_ch.data[ANGLE_W-1:0];
          REG_ARM_CLOSE:  arm_close_r  <= cfg_ch.data[ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (parse.done) begin
        x_dir_r       <= parse.x_dir;
        y_dir_r       <= parse.y_dir;
        z_dir_r       <= parse.z_dir;
        arm_is_open_r <= (parse.arm_code == DIR_FWD);
      end else if (tick_acc) begin
        if (in_ch.x_start_hit || in_ch.x_end_hit) begin
          x_dir_r <= DIR_STOP;
        end
        if (in_ch.y_start_hit || in_ch.y_end_hit) begin
          y_dir_r <= DIR_STOP;
        end
        if (in_ch.z_top_hit) begin
          z_dir_r <= DIR_STOP;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (tick_acc) begin
      hit_r <= {in_ch.z_top_hit, in_ch.y_end_hit, in_ch.y_start_hit, in_ch.x_end_hit,
                in_ch.x_start_hit};
    end
    if (state_r == S_TICK && axis_r == AX_X) begin
      px_r <= pulse;
    end
    if (state_r == S_TICK && axis_r == AX_Y) begin
      py_r <= pulse;
    end
    if (state_r == S_TICK && axis_r == AX_Z) begin
      pz_r <= pulse;
    end
    if (out_load) begin
      out_px_r  <= px_r;
      out_py_r  <= py_r;
      out_pz_r  <= pz_r;
      out_arm_r <= arm_is_open_r ? arm_open_r : arm_close_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pulse_x   = out_px_r;
  assign out_ch.pulse_y   = out_py_r;
  assign out_ch.pulse_z   = out_pz_r;
  assign out_ch.arm_angle = out_arm_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the line command servo limit controller core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcs_pkg::*;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Switch masks in the order x start, x end, y start, y end, z top.
  localparam logic [4:0] SW_NONE    = 5'b00000;
  localparam logic [4:0] SW_X_START = 5'b10000;
  localparam logic [4:0] SW_X_END   = 5'b01000;
  localparam logic [4:0] SW_Y_START = 5'b00100;
  localparam logic [4:0] SW_Y_END   = 5'b00010;
  localparam logic [4:0] SW_Z_TOP   = 5'b00001;
  localparam logic [4:0] SW_ALL     = 5'b11111;

  localparam int SETTLE_CYCLES = LCS_LINE_DEPTH + 16;
  localparam int PULSE_MAX     = (1 << PULSE_W) - 1;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_x;
    logic [PULSE_W-1:0] pulse_y;
    logic [PULSE_W-1:0] pulse_z;
    logic [ANGLE_W-1:0] arm_angle;
  } servo_word_t;

  typedef struct {
    logic [PULSE_W-1:0]       stop_us;
    logic signed [STEP_W-1:0] x_off;
    logic signed [STEP_W-1:0] y_off;
    logic signed [STEP_W-1:0] z_off;
    logic [ANGLE_W-1:0]       open_deg;
    logic [ANGLE_W-1:0]       close_deg;
  } reg_set_t;

  logic clk = 1'b0;
  logic rst_n;

  lcs_in_if  in_if();
  lcs_out_if out_if();
  lcs_cfg_if cfg_if();

  line_command_servo_limit_controller_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted controller state and register copy.
  char_t                    line_buf [LCS_LINE_DEPTH];
  int                       line_len;
  logic [1:0]               x_dir, y_dir, z_dir;
  logic                     arm_open;
  logic [PULSE_W-1:0]       stop_us;
  logic signed [STEP_W-1:0] x_off, y_off, z_off;
  logic [ANGLE_W-1:0]       open_deg, close_deg;

  servo_word_t pending_pulses[$];
  char_t       text_q[$];
  int          failures;
  int          words_sent;
  int          gap_pct;
  int          stall_pct;
  int          hold_off_cycles;

  function automatic logic [PULSE_W-1:0] clamp_pulse(input int v);
    if (v < 0) return '0;
    if (v > PULSE_MAX) return '1;
    return v[PULSE_W-1:0];
  endfunction

  function automatic logic [PULSE_W-1:0] axis_pulse(input logic [1:0] code, input int step);
    case (code)
      DIR_FWD: return clamp_pulse(int'(stop_us) + step);
      DIR_REV: return clamp_pulse(int'(stop_us) - step);
      default: return clamp_pulse(int'(stop_us));
    endcase
  endfunction

  function automatic logic [1:0] field_dir(input int from, input int upto);
    int   i;
    logic neg;
    int   mag;
    i = from;
    neg = 1'b0;
    mag = 0;
    while (i < upto && (line_buf[i] == CH_SPACE || line_buf[i] == CH_TAB ||
                        line_buf[i] == CH_LF || line_buf[i] == CH_VT ||
                        line_buf[i] == CH_FF || line_buf[i] == CH_CR))
      i++;
    if (i < upto && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS)) begin
      neg = (line_buf[i] == CH_MINUS);
      i++;
    end
    while (i < upto && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE) begin
      mag = mag * 10 + int'(line_buf[i] - CH_ZERO);
      if (mag > 2) mag = 2;
      i++;
    end
    if (mag != 1) return DIR_STOP;
    return neg ? DIR_REV : DIR_FWD;
  endfunction

  function automatic void run_line();
    logic [1:0] codes [LCS_FIELD_COUNT];
    int         nf;
    int         from;
    foreach (codes[k]) codes[k] = DIR_STOP;
    nf = 0;
    from = 0;
    for (int i = 0; i < line_len && nf < LCS_FIELD_COUNT; i++) begin
      if (line_buf[i] == CH_COMMA) begin
        codes[nf] = field_dir(from, i);
        nf++;
        from = i + 1;
      end
    end
    if (nf < LCS_FIELD_COUNT) codes[nf] = field_dir(from, line_len);
    x_dir = codes[0];
    y_dir = codes[1];
    z_dir = codes[2];
    arm_open = (codes[3] == DIR_FWD);
  endfunction

  function automatic void advance_controller(input logic cmd, input char_t ch,
                                             input logic [4:0] sw);
    servo_word_t r;
    int          s;
    s = int'(stop_us);
    if (cmd == CMD_CHAR) begin
      case (ch)
        CH_CR: ;
        CH_LF: begin
          run_line();
          line_len = 0;
        end
        CH_BS: if (line_len > 0) line_len--;
        default: if (line_len < LCS_LINE_DEPTH) begin
          line_buf[line_len] = ch;
          line_len++;
        end
      endcase
    end else begin
      if (sw[4]) begin
        r.pulse_x = clamp_pulse(s + int'(x_off));
        x_dir = DIR_STOP;
      end else if (sw[3]) begin
        r.pulse_x = clamp_pulse(s - int'(x_off));
        x_dir = DIR_STOP;
      end else begin
        r.pulse_x = axis_pulse(x_dir, int'(x_off));
      end
      if (sw[2]) begin
        r.pulse_y = clamp_pulse(s + int'(y_off));
        y_dir = DIR_STOP;
      end else if (sw[1]) begin
        r.pulse_y = clamp_pulse(s - int'(y_off));
        y_dir = DIR_STOP;
      end else begin
        r.pulse_y = axis_pulse(y_dir, int'(y_off));
      end
      if (sw[0]) begin
        r.pulse_z = clamp_pulse(s + int'(z_off));
        z_dir = DIR_STOP;
      end else begin
        r.pulse_z = axis_pulse(z_dir, -int'(z_off));
      end
      r.arm_angle = arm_open ? open_deg : close_deg;
      pending_pulses.push_back(r);
    end
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_STOP_PULSE: stop_us   = val[PULSE_W-1:0];
      REG_X_STEP:     x_off     = val[STEP_W-1:0];
      REG_Y_STEP:     y_off     = val[STEP_W-1:0];
      REG_Z_STEP:     z_off     = val[STEP_W-1:0];
      REG_ARM_OPEN:   open_deg  = val[ANGLE_W-1:0];
      REG_ARM_CLOSE:  close_deg = val[ANGLE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : track_accepts
    if (rst_n && in_if.valid && in_if.ready)
      advance_controller(in_if.command, in_if.char_byte,
                         {in_if.x_start_hit, in_if.x_end_hit, in_if.y_start_hit,
                          in_if.y_end_hit, in_if.z_top_hit});
    if (rst_n && cfg_if.valid && cfg_if.ready)
      apply_reg_write(cfg_if.index, cfg_if.data);
  end

  always @(posedge clk) begin : check_results
    servo_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pulses.size() == 0) begin
        failures++;
        $display("%0t ns: unexpected word, expected none, actual x=%0d y=%0d z=%0d arm=%0d",
                 $time, out_if.pulse_x, out_if.pulse_y, out_if.pulse_z, out_if.arm_angle);
      end else begin
        want = pending_pulses.pop_front();
        check_field("pulse_x", want.pulse_x, out_if.pulse_x);
        check_field("pulse_y", want.pulse_y, out_if.pulse_y);
        check_field("pulse_z", want.pulse_z, out_if.pulse_z);
        check_field("arm_angle", want.arm_angle, out_if.arm_angle);
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_left = hold_off_cycles;
        hold_off_cycles = 0;
        out_if.ready <= 1'b0;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic cmd, input char_t ch, input logic [4:0] sw);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.char_byte <= ch;
    {in_if.x_start_hit, in_if.x_end_hit, in_if.y_start_hit, in_if.y_end_hit,
     in_if.z_top_hit} <= sw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_tick(input logic [4:0] sw);
    send_word(CMD_TICK, char_t'($urandom_range(255)), sw);
  endtask

  task automatic send_random_ticks();
    int n;
    n = $urandom_range(3);
    repeat (n) send_tick(($urandom_range(9) < 3) ? 5'($urandom_range(31)) : SW_NONE);
  endtask

  // Sends the text queue; with noise on, stray carriage returns and deleted
  // characters are slipped in between the real ones.
  task automatic send_text(input bit noisy);
    foreach (text_q[i]) begin
      if (noisy && $urandom_range(99) < 4) send_word(CMD_CHAR, CH_CR, 5'($urandom_range(31)));
      if (noisy && $urandom_range(99) < 4) begin
        send_word(CMD_CHAR, char_t'($urandom_range(8'h21, 8'h7E)), 5'($urandom_range(31)));
        send_word(CMD_CHAR, CH_BS, 5'($urandom_range(31)));
      end
      send_word(CMD_CHAR, text_q[i], 5'($urandom_range(31)));
    end
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(char_t'(s[i]));
  endfunction

  function automatic string random_field();
    case ($urandom_range(15))
      0, 1, 2: return "1";
      3, 4, 5: return "-1";
      6:       return "+1";
      7:       return "0";
      8:       return "2";
      9:       return "0001";
      10:      return "12345678901234567890";
      11:      return "-";
      12:      return "";
      13:      return "1x5";
      14:      return "-0000001";
      default: return $sformatf("%0d", $urandom_range(99));
    endcase
  endfunction

  function automatic char_t random_blank();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic void build_overlong_line();
    int n;
    n = $urandom_range(LCS_LINE_DEPTH + 1, LCS_LINE_DEPTH + 30);
    text_q.delete();
    repeat (n) begin
      case ($urandom_range(4))
        0:       text_q.push_back(CH_COMMA);
        1:       text_q.push_back(CH_MINUS);
        2:       text_q.push_back(CH_SPACE);
        default: text_q.push_back(char_t'(CH_ZERO + $urandom_range(2)));
      endcase
    end
    text_q.push_back(CH_LF);
  endfunction

  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Unused upper data bits are filled at random; the block must ignore them.
  task automatic program_regs(input reg_set_t rs);
    settle_idle();
    write_reg(REG_STOP_PULSE, rs.stop_us);
    write_reg(REG_X_STEP, {2'($urandom_range(3)), rs.x_off});
    write_reg(REG_Y_STEP, {2'($urandom_range(3)), rs.y_off});
    write_reg(REG_Z_STEP, {2'($urandom_range(3)), rs.z_off});
    write_reg(REG_ARM_OPEN, {4'($urandom_range(15)), rs.open_deg});
    write_reg(REG_ARM_CLOSE, {4'($urandom_range(15)), rs.close_deg});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_directed_lines();
    send_tick(SW_NONE);
    text_q.delete();
    text_q.push_back(CH_BS);
    push_text("-1,+1");
    text_q.push_back(CH_CR);
    push_text(",1,1");
    text_q.push_back(CH_LF);
    send_text(1'b0);
    send_tick(SW_NONE);
    send_tick(SW_ALL);
    send_tick(SW_NONE);
    text_q.delete();
    push_text("1,-1");
    text_q.push_back(CH_LF);
    send_text(1'b0);
    send_tick(SW_X_END | SW_Y_END);
    send_tick(SW_X_START | SW_Y_START | SW_Z_TOP);
  endtask

  task automatic test_random_lines(input int n_words);
    int stop_at;
    int pick;
    int nf;
    stop_at = words_sent + n_words;
    build_overlong_line();
    send_text(1'b0);
    send_random_ticks();
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      text_q.delete();
      if (pick < 72) begin
        nf = $urandom_range(1, 6);
        for (int k = 0; k < nf; k++) begin
          if (k != 0) text_q.push_back(CH_COMMA);
          if ($urandom_range(4) == 0) text_q.push_back(random_blank());
          push_text(random_field());
        end
        if ($urandom_range(19) != 0) text_q.push_back(CH_LF);
      end else if (pick < 82) begin
        repeat ($urandom_range(80)) text_q.push_back(char_t'($urandom_range(255)));
        text_q.push_back(CH_LF);
      end else if (pick < 88) begin
        build_overlong_line();
      end else if (pick < 94) begin
        text_q.push_back(CH_LF);
      end else begin
        repeat ($urandom_range(1, 6)) text_q.push_back(char_t'($urandom_range(255)));
      end
      send_text(1'b1);
      send_random_ticks();
    end
  endtask

  task automatic test_register_extremes();
    reg_set_t sets [4];
    sets[0] = '{12'd4095, 10'sd511, 10'sd511, -10'sd512, 8'd255, 8'd0};
    sets[1] = '{12'd0, -10'sd512, 10'sd511, 10'sd511, 8'd0, 8'd180};
    sets[2] = '{12'd500, -10'sd500, 10'sd500, -10'sd500, 8'd180, 8'd0};
    sets[3] = '{12'd2500, 10'sd500, -10'sd500, 10'sd500, 8'd0, 8'd180};
    foreach (sets[i]) begin
      program_regs(sets[i]);
      test_random_lines(150);
    end
  endtask

  task automatic test_random_registers();
    reg_set_t rs;
    repeat (2) begin
      rs.stop_us   = 12'($urandom_range(4095));
      rs.x_off     = 10'($urandom_range(1023));
      rs.y_off     = 10'($urandom_range(1023));
      rs.z_off     = 10'($urandom_range(1023));
      rs.open_deg  = 8'($urandom_range(255));
      rs.close_deg = 8'($urandom_range(255));
      program_regs(rs);
      test_random_lines(160);
    end
  endtask

  task automatic test_unknown_registers();
    reg_set_t rs;
    rs = '{RST_STOP_PULSE, RST_X_STEP, RST_Y_STEP, RST_Z_STEP, RST_ARM_OPEN, RST_ARM_CLOSE};
    program_regs(rs);
    @(posedge clk);
    write_reg(REG_SPARE_LO, 12'($urandom_range(4095)));
    write_reg(REG_SPARE_HI, 12'($urandom_range(4095)));
    cfg_if.valid <= 1'b0;
    test_random_lines(60);
  endtask

  task automatic test_no_idling();
    gap_pct = 0;
    stall_pct = 0;
    test_random_lines(200);
    gap_pct = 36;
    stall_pct = 36;
  endtask

  task automatic test_output_backpressure();
    gap_pct = 0;
    hold_off_cycles = 300;
    repeat (40) send_tick(5'($urandom_range(31)));
    gap_pct = 36;
  endtask

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_CHAR;
    in_if.char_byte = '0;
    in_if.x_start_hit = 1'b0;
    in_if.x_end_hit = 1'b0;
    in_if.y_start_hit = 1'b0;
    in_if.y_end_hit = 1'b0;
    in_if.z_top_hit = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_STOP_PULSE;
    cfg_if.data = '0;
    failures = 0;
    words_sent = 0;
    gap_pct = 36;
    stall_pct = 36;
    hold_off_cycles = 0;
    foreach (line_buf[i]) line_buf[i] = '0;
    line_len = 0;
    x_dir = DIR_STOP;
    y_dir = DIR_STOP;
    z_dir = DIR_STOP;
    arm_open = 1'b1;
    stop_us = RST_STOP_PULSE;
    x_off = RST_X_STEP;
    y_off = RST_Y_STEP;
    z_off = RST_Z_STEP;
    open_deg = RST_ARM_OPEN;
    close_deg = RST_ARM_CLOSE;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_random_lines(300);
    test_register_extremes();
    test_unknown_registers();
    test_no_idling();
    test_output_backpressure();
    test_random_registers();

    settle_idle();
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcs_pkg.sv
rtl/lcs_in_if.sv
rtl/lcs_out_if.sv
rtl/lcs_cfg_if.sv
rtl/lcs_ram.sv
rtl/lcs_line_parser.sv
rtl/lcs_pulse_unit.sv
rtl/line_command_servo_limit_controller_core.sv
tb/tb_top.sv
